@@ hw/rtl/focal_list_node_selector_assert.svh @@
// Assertion macros shared by the focal list node selector RTL.
// Each macro expects i_clk and i_rst_n to be visible in the including module.
`ifndef FOCAL_LIST_NODE_SELECTOR_ASSERT_SVH
`define FOCAL_LIST_NODE_SELECTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FLNS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FLNS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/flns_pkg.sv @@
// Types and constants of the focal list node selector.
// Used by flns_store, flns_cmp and focal_list_node_selector; depends on nothing.
`default_nettype none

package flns_pkg;

    localparam int unsigned FIELD_W   = 16;
    localparam int unsigned WEIGHT_W  = 12;
    localparam int unsigned BOUND_W   = FIELD_W + WEIGHT_W;
    localparam int unsigned HELD_W    = 7;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 12'd256;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 12'd256;
    localparam logic [FIELD_W-1:0]  LIMIT_RESET  = 16'd500;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'b1;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_POP    = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2,
        STS_LIMIT = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SCAN_FREE  = 2'd0,
        SCAN_MIN   = 2'd1,
        SCAN_FOCAL = 2'd2
    } t_scan;

    typedef struct packed {
        logic [FIELD_W-1:0] stamp;
        logic [FIELD_W-1:0] tag;
        logic [FIELD_W-1:0] conf;
        logic [FIELD_W-1:0] cost;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry ent;
    } t_slot;

    // Inputs of the shared compare unit.
    typedef struct packed {
        t_scan              mode;
        logic               have;
        t_entry             best;
        logic [BOUND_W-1:0] bound;
    } t_cmp_ctl;

endpackage

`default_nettype wire

@@ hw/rtl/focal_list_node_selector.sv @@
// One request is handled at a time: an insert scans the table for a free slot, a pop scans
// for the minimum cost and then for the focal slot (unless it reports empty or limit), and a
// clear rewrites every slot. The next request is taken in the cycle after the result is
// registered. The scans are serial because the slot table has a single read port. After
// reset a clearing pass over every slot runs before the first request is taken;
// configuration writes are taken throughout.
`default_nettype none

module focal_list_node_selector #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [47:0] i_s_tdata,  // node_cost, node_conflicts, node_tag
    input  wire logic [1:0]  i_s_tuser,  // req_type
    // Result stream.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [55:0]      o_m_tdata,  // out_tag, out_cost, out_conflicts, entries_held, pad
    output logic [1:0]       o_m_tuser,  // status
    // Configuration write channel.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [flns_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    `include "focal_list_node_selector_assert.svh"

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [AW:0]   SCAN_END  = (AW+1)'(TABLE_DEPTH);
    localparam logic [AW:0]   CLEAR_END = (AW+1)'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0] HELD_MAX  = CW'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_INSERT,
        ST_REMOVE,
        ST_RESP
    } t_state;

    t_state r_state, n_state;
    flns_pkg::t_scan r_mode, n_mode;
    logic [AW:0]   r_cnt, n_cnt;
    logic          r_dv, n_dv;
    logic [AW-1:0] r_didx, n_didx;
    logic          r_have, n_have;
    flns_pkg::t_entry r_best, n_best;
    logic [AW-1:0] r_best_idx, n_best_idx;
    logic [flns_pkg::BOUND_W-1:0] r_bound, n_bound;
    logic [15:0]   r_in_cost, n_in_cost;
    logic [15:0]   r_in_conf, n_in_conf;
    logic [15:0]   r_in_tag, n_in_tag;
    logic [15:0]   r_stamp, n_stamp;
    logic [15:0]   r_pops, n_pops;
    logic [CW-1:0] r_held, n_held;
    logic          r_clr_rsp, n_clr_rsp;
    flns_pkg::t_status r_rsp_sts, n_rsp_sts;
    logic          r_rsp_pop, n_rsp_pop;
    logic          r_m_tvalid, n_m_tvalid;
    logic [55:0]   r_m_tdata, n_m_tdata;
    logic [1:0]    r_m_tuser, n_m_tuser;
    logic [flns_pkg::WEIGHT_W-1:0] r_weight;
    logic [15:0]   r_limit;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    flns_pkg::t_slot w_wdata;
    flns_pkg::t_slot w_rdata;
    flns_pkg::t_cmp_ctl w_ctl;
    logic          w_take;
    logic [flns_pkg::WEIGHT_W-1:0] w_weight;
    logic [CW+6:0] w_held_wide;
    logic [15:0]   w_tag, w_cost, w_conf;

    flns_store #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_ctl.mode  = r_mode;
    assign w_ctl.have  = r_have;
    assign w_ctl.best  = r_best;
    assign w_ctl.bound = r_bound;

    flns_cmp u_cmp (
        .i_slot (w_rdata),
        .i_ctl  (w_ctl),
        .o_take (w_take)
    );

    // Weights below one are treated as one, so minimum-cost slots are always focal.
    assign w_weight    = (r_weight < flns_pkg::WEIGHT_ONE) ? flns_pkg::WEIGHT_ONE : r_weight;
    assign w_held_wide = {7'b0000000, r_held};
    assign w_tag       = r_rsp_pop ? r_best.tag  : 16'h0000;
    assign w_cost      = r_rsp_pop ? r_best.cost : 16'h0000;
    assign w_conf      = r_rsp_pop ? r_best.conf : 16'h0000;

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_m_tvalid  = r_m_tvalid;
    assign o_m_tdata   = r_m_tdata;
    assign o_m_tuser   = r_m_tuser;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_cnt      = r_cnt;
        n_dv       = 1'b0;
        n_didx     = r_didx;
        n_have     = r_have;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_bound    = r_bound;
        n_in_cost  = r_in_cost;
        n_in_conf  = r_in_conf;
        n_in_tag   = r_in_tag;
        n_stamp    = r_stamp;
        n_pops     = r_pops;
        n_held     = r_held;
        n_clr_rsp  = r_clr_rsp;
        n_rsp_sts  = r_rsp_sts;
        n_rsp_pop  = r_rsp_pop;
        n_m_tvalid = r_m_tvalid && !i_m_tready;
        n_m_tdata  = r_m_tdata;
        n_m_tuser  = r_m_tuser;
        w_we       = 1'b0;
        w_waddr    = r_cnt[AW-1:0];
        w_wdata    = '0;

        case (r_state)
            ST_CLEAR: begin
                w_we  = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CLEAR_END) begin
                    n_state   = r_clr_rsp ? ST_RESP : ST_IDLE;
                    n_rsp_sts = flns_pkg::STS_OK;
                    n_rsp_pop = 1'b0;
                end
            end
            ST_IDLE: begin
                n_cnt     = '0;
                n_have    = 1'b0;
                n_rsp_pop = 1'b0;
                n_rsp_sts = flns_pkg::STS_OK;
                n_in_cost = i_s_tdata[15:0];
                n_in_conf = i_s_tdata[31:16];
                n_in_tag  = i_s_tdata[47:32];
                if (i_s_tvalid) begin
                    case (flns_pkg::t_req'(i_s_tuser))
                        flns_pkg::REQ_INSERT: begin
                            n_mode  = flns_pkg::SCAN_FREE;
                            n_state = ST_SCAN;
                        end
                        flns_pkg::REQ_POP: begin
                            n_mode  = flns_pkg::SCAN_MIN;
                            n_state = ST_SCAN;
                        end
                        flns_pkg::REQ_CLEAR: begin
                            n_stamp   = '0;
                            n_pops    = '0;
                            n_held    = '0;
                            n_clr_rsp = 1'b1;
                            n_state   = ST_CLEAR;
                        end
                        default: begin
                            n_state = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Address r_cnt is issued now; the slot read last cycle is judged now.
                if (r_cnt != SCAN_END) begin
                    n_cnt  = r_cnt + 1'b1;
                    n_dv   = 1'b1;
                    n_didx = r_cnt[AW-1:0];
                end
                if (r_dv && w_take) begin
                    n_best     = w_rdata.ent;
                    n_best_idx = r_didx;
                    n_have     = 1'b1;
                end
                if (r_cnt == SCAN_END) begin
                    case (r_mode)
                        flns_pkg::SCAN_FREE: begin
                            n_state = ST_INSERT;
                        end
                        flns_pkg::SCAN_MIN: begin
                            if (!n_have) begin
                                n_rsp_sts = flns_pkg::STS_EMPTY;
                                n_state   = ST_RESP;
                            end else if (r_pops >= r_limit) begin
                                n_rsp_sts = flns_pkg::STS_LIMIT;
                                n_state   = ST_RESP;
                            end else begin
                                n_state = ST_MUL;
                            end
                        end
                        default: begin
                            n_state = ST_REMOVE;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                n_bound = r_best.cost * w_weight;
                n_mode  = flns_pkg::SCAN_FOCAL;
                n_cnt   = '0;
                n_have  = 1'b0;
                n_state = ST_SCAN;
            end
            ST_INSERT: begin
                if (r_have) begin
                    w_we      = 1'b1;
                    w_waddr   = r_best_idx;
                    w_wdata   = {1'b1, r_stamp, r_in_tag, r_in_conf, r_in_cost};
                    n_stamp   = r_stamp + 1'b1;
                    n_held    = r_held + 1'b1;
                    n_rsp_sts = flns_pkg::STS_OK;
                end else begin
                    n_rsp_sts = flns_pkg::STS_FULL;
                end
                n_state = ST_RESP;
            end
            ST_REMOVE: begin
                w_we      = 1'b1;
                w_waddr   = r_best_idx;
                w_wdata   = {1'b0, r_best};
                n_held    = r_held - 1'b1;
                n_pops    = r_pops + 1'b1;
                n_rsp_sts = flns_pkg::STS_OK;
                n_rsp_pop = 1'b1;
                n_state   = ST_RESP;
            end
            ST_RESP: begin
                if (!r_m_tvalid || i_m_tready) begin
                    n_m_tvalid = 1'b1;
                    n_m_tdata  = {1'b0, w_held_wide[6:0], w_conf, w_cost, w_tag};
                    n_m_tuser  = r_rsp_sts;
                    n_clr_rsp  = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_mode     <= flns_pkg::SCAN_FREE;
            r_cnt      <= '0;
            r_dv       <= 1'b0;
            r_have     <= 1'b0;
            r_stamp    <= '0;
            r_pops     <= '0;
            r_held     <= '0;
            r_clr_rsp  <= 1'b0;
            r_rsp_sts  <= flns_pkg::STS_OK;
            r_rsp_pop  <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_cnt      <= n_cnt;
            r_dv       <= n_dv;
            r_have     <= n_have;
            r_stamp    <= n_stamp;
            r_pops     <= n_pops;
            r_held     <= n_held;
            r_clr_rsp  <= n_clr_rsp;
            r_rsp_sts  <= n_rsp_sts;
            r_rsp_pop  <= n_rsp_pop;
            r_m_tvalid <= n_m_tvalid;
        end
        r_didx     <= n_didx;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_bound    <= n_bound;
        r_in_cost  <= n_in_cost;
        r_in_conf  <= n_in_conf;
        r_in_tag   <= n_in_tag;
        r_m_tdata  <= n_m_tdata;
        r_m_tuser  <= n_m_tuser;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= flns_pkg::WEIGHT_RESET;
            r_limit  <= flns_pkg::LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                flns_pkg::CFG_WEIGHT: r_weight <= i_cfg_data[flns_pkg::WEIGHT_W-1:0];
                flns_pkg::CFG_LIMIT:  r_limit  <= i_cfg_data;
                default:              r_limit  <= r_limit;
            endcase
        end
    end

    `FLNS_ASSERT_NEXT(a_busy_after_accept, i_s_tvalid && o_s_tready, !o_s_tready,
        "request accepted but input still ready next cycle")
    `FLNS_ASSERT_IMPL(a_insert_has_room, (r_state == ST_INSERT) && r_have, r_held < HELD_MAX,
        "free slot found while the table counts as full")
    `FLNS_ASSERT_IMPL(a_focal_found, r_state == ST_REMOVE, r_have,
        "focal pass ended without a candidate")
    `FLNS_ASSERT_NEXT(a_remove_count, r_state == ST_REMOVE, r_held == $past(r_held) - 1'b1,
        "held count not reduced by a successful pop")

endmodule

`default_nettype wire

@@ hw/rtl/flns_store.sv @@
// Slot table of the focal list node selector: one write and one registered read port.
// Depends on flns_pkg for the slot type.
`default_nettype none

module flns_store #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire flns_pkg::t_slot  i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output flns_pkg::t_slot       o_rdata
);

    flns_pkg::t_slot r_mem [DEPTH];
    flns_pkg::t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/flns_cmp.sv @@
// Shared compare unit: decides whether the slot just read replaces the current best.
// Serves the free-slot, minimum-cost and focal passes; depends on flns_pkg.
`default_nettype none

module flns_cmp (
    input  wire flns_pkg::t_slot    i_slot,
    input  wire flns_pkg::t_cmp_ctl i_ctl,
    output logic                    o_take
);

    logic                         w_cost_lt;
    logic                         w_cost_eq;
    logic                         w_better;
    logic                         w_focal;
    logic [flns_pkg::BOUND_W-1:0] w_scaled;

    assign w_cost_lt = i_slot.ent.cost < i_ctl.best.cost;
    assign w_cost_eq = i_slot.ent.cost == i_ctl.best.cost;
    // Fewest conflicts first, then lower cost, then the earlier stamp.
    assign w_better  = (i_slot.ent.conf < i_ctl.best.conf) ||
                       ((i_slot.ent.conf == i_ctl.best.conf) &&
                        (w_cost_lt || (w_cost_eq && (i_slot.ent.stamp < i_ctl.best.stamp))));
    assign w_scaled  = {4'b0000, i_slot.ent.cost, 8'h00};
    assign w_focal   = w_scaled <= i_ctl.bound;

    always_comb begin
        case (i_ctl.mode)
            flns_pkg::SCAN_FREE:  o_take = !i_slot.valid && !i_ctl.have;
            flns_pkg::SCAN_MIN:   o_take = i_slot.valid && (!i_ctl.have || w_cost_lt);
            flns_pkg::SCAN_FOCAL: o_take = i_slot.valid && w_focal && (!i_ctl.have || w_better);
            default:              o_take = 1'b0;
        endcase
    end

endmodule

`default_nettype wire
